/* rtl/assert_macros.svh */
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define HWMA_ASSERT_NOW(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed: lbl");

// next-cycle implication, checked outside reset
`define HWMA_ASSERT_NEXT(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed: lbl");

`endif

/* rtl/hwma_pkg.sv */
package hwma_pkg;

  localparam int DATA_W    = 64;
  localparam int BCNT_W    = 4;
  localparam int IDX_W     = 31;
  localparam int AVG_W     = 13;
  localparam int CHUNK_W   = 7;   // popcount of one chunk, 0..64
  localparam int REG_IDX_W = 1;

  localparam logic [IDX_W-1:0] IDX_MAX = {IDX_W{1'b1}};
  localparam logic [AVG_W-1:0] AVG_MAX = {AVG_W{1'b1}};
  localparam logic [BCNT_W-1:0] BYTES_PER_CHUNK = 4'd8;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_WINDOW_START = 1'b0,
    REG_WINDOW_END   = 1'b1
  } reg_idx_t;

  // set bits in the valid low bytes of a chunk; counts above eight act as eight
  function automatic logic [CHUNK_W-1:0] chunk_weight(input logic [DATA_W-1:0] data,
                                                      input logic [BCNT_W-1:0] cnt);
    logic [BCNT_W-1:0]  eff;
    logic [CHUNK_W-1:0] n;
    eff = (cnt > BYTES_PER_CHUNK) ? BYTES_PER_CHUNK : cnt;
    n   = '0;
    for (int b = 0; b < 8; b++) begin
      if (BCNT_W'(b) < eff) begin
        for (int i = 0; i < 8; i++) begin
          n = n + CHUNK_W'(data[8*b+i]);
        end
      end
    end
    return n;
  endfunction

endpackage

/* rtl/hamming_weight_moving_average.sv */
// channel   direction  fields                                  handshake
// in        sink       data_chunk, byte_count, last_chunk      in_valid / in_stall
// out       source     average_tenths, access_index            out_valid / out_stall
// cfg       sink       cfg_index, cfg_data                     cfg_write
//
// One chunk per cycle while in_stall is low. A closing chunk inside the window
// whose offset from window_start is at least WINDOW_LEN produces its average
// through registered stages for ring write and sum, numerator, reciprocal
// multiply, and shift and clamp. The ring sits in one memory with one read and
// one write per cycle, which sets the one-transaction-per-cycle rate. Reset
// clears all control state; ring entries read as zero until written, tracked by
// one valid bit each. A stall on out backs up through the stages only as far as they are full.
`include "assert_macros.svh"

module hamming_weight_moving_average #(
  parameter int WINDOW_LEN       = 10,
  parameter int MAX_ACCESS_BYTES = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [hwma_pkg::DATA_W-1:0]    data_chunk,
  input  logic [hwma_pkg::BCNT_W-1:0]    byte_count,
  input  logic                           last_chunk,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [hwma_pkg::AVG_W-1:0]     average_tenths,
  output logic [hwma_pkg::IDX_W-1:0]     access_index,
  input  logic                           cfg_write,
  input  logic [hwma_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [hwma_pkg::IDX_W-1:0]     cfg_data
);
  import hwma_pkg::*;

  localparam int MAX_WEIGHT = 8 * MAX_ACCESS_BYTES;
  localparam int WW   = $clog2(MAX_WEIGHT + 1);
  localparam int AW   = ((WW > CHUNK_W) ? WW : CHUNK_W) + 1;
  localparam int SUM_MAX = WINDOW_LEN * MAX_WEIGHT;
  localparam int SW   = $clog2(SUM_MAX + 1);
  localparam int PW   = $clog2(WINDOW_LEN);
  localparam int NW   = $clog2(SUM_MAX * 10 + WINDOW_LEN / 2 + 1);
  localparam int K    = NW + $clog2(WINDOW_LEN);
  localparam int PRW  = NW + K;
  localparam int QW   = (NW > AVG_W) ? NW : AVG_W;
  localparam longint unsigned RECIP_L =
    ((64'd1 << K) + longint'(WINDOW_LEN) - 64'd1) / longint'(WINDOW_LEN);
  localparam logic [K-1:0] RECIP = RECIP_L[K-1:0];
  localparam logic [PW-1:0] POS_LAST = PW'(WINDOW_LEN - 1);

  // configuration
  logic [IDX_W-1:0] window_start;
  logic [IDX_W-1:0] window_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_start <= '0;
      window_end   <= IDX_MAX;
    end else if (cfg_write) begin
      case (reg_idx_t'(cfg_index))
        REG_WINDOW_START: window_start <= cfg_data;
        REG_WINDOW_END:   window_end   <= cfg_data;
        default:          ;
      endcase
    end
  end

  // stage handshakes
  logic b_v, c_v, d_v;
  logic o_ready, d_ready, c_ready, b_ready;
  logic in_fire, b_fire;

  assign o_ready  = !out_valid || !out_stall;
  assign d_ready  = !d_v || o_ready;
  assign c_ready  = !c_v || d_ready;
  assign b_ready  = !b_v || c_ready;
  assign in_stall = !b_ready;
  assign in_fire  = in_valid && b_ready;
  assign b_fire   = b_v && c_ready;

  // accept stage: weight accumulation and window test
  logic [WW-1:0]    partial_weight;
  logic [IDX_W-1:0] access_counter;
  logic [PW-1:0]    ring_pos;
  logic [AW-1:0]    w_raw;
  logic [WW-1:0]    w_sat;
  logic             in_win, emit;
  logic [IDX_W-1:0] idx_off;

  assign w_raw   = AW'(partial_weight) + AW'(chunk_weight(data_chunk, byte_count));
  assign w_sat   = (w_raw > AW'(MAX_WEIGHT)) ? WW'(MAX_WEIGHT) : w_raw[WW-1:0];
  assign in_win  = (access_counter >= window_start) && (access_counter < window_end);
  assign idx_off = access_counter - window_start;
  assign emit    = (idx_off >= IDX_W'(WINDOW_LEN));

  always_ff @(posedge clk) begin
    if (rst) begin
      partial_weight <= '0;
      access_counter <= '0;
      ring_pos       <= '0;
    end else if (in_fire) begin
      if (last_chunk) begin
        partial_weight <= '0;
        if (access_counter != IDX_MAX) begin
          access_counter <= access_counter + 1'b1;
        end
        if (in_win) begin
          ring_pos <= (ring_pos == POS_LAST) ? '0 : ring_pos + 1'b1;
        end
      end else begin
        partial_weight <= w_sat;
      end
    end
  end

  // ring memory: read at accept, written back one stage later
  logic [WW-1:0] ring_mem [WINDOW_LEN];
  logic [WW-1:0] ring_rdata;
  logic [WINDOW_LEN-1:0] ring_valid;

  always_ff @(posedge clk) begin
    if (b_ready) begin
      ring_rdata <= ring_mem[ring_pos];
    end
  end

  logic [WW-1:0]    b_weight;
  logic [PW-1:0]    b_pos;
  logic             b_emit;
  logic [IDX_W-1:0] b_idx;

  always_ff @(posedge clk) begin
    if (b_fire) begin
      ring_mem[b_pos] <= b_weight;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_valid <= '0;
    end else if (b_fire) begin
      ring_valid[b_pos] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_v <= 1'b0;
    end else if (b_ready) begin
      b_v <= in_fire && last_chunk && in_win;
    end
  end

  always_ff @(posedge clk) begin
    if (b_ready) begin
      b_weight <= w_sat;
      b_pos    <= ring_pos;
      b_emit   <= emit;
      b_idx    <= access_counter;
    end
  end

  // sum update
  logic [SW-1:0] window_sum;
  logic [WW-1:0] old_weight;
  logic [SW:0]   sum_wide;

  assign old_weight = ring_valid[b_pos] ? ring_rdata : '0;
  assign sum_wide   = (SW+1)'(window_sum) - (SW+1)'(old_weight) + (SW+1)'(b_weight);

  always_ff @(posedge clk) begin
    if (rst) begin
      window_sum <= '0;
    end else if (b_fire) begin
      window_sum <= sum_wide[SW-1:0];
    end
  end

  // average: round(sum * 10 / WINDOW_LEN) by reciprocal multiply
  logic [SW-1:0]    c_sum;
  logic [IDX_W-1:0] c_idx;
  logic [NW-1:0]    c_num;
  logic [PRW-1:0]   d_prod;
  logic [IDX_W-1:0] d_idx;
  logic [QW-1:0]    d_quot;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_v <= 1'b0;
    end else if (c_ready) begin
      c_v <= b_v && b_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (c_ready) begin
      c_sum <= sum_wide[SW-1:0];
      c_idx <= b_idx;
    end
  end

  assign c_num = (NW'(c_sum) << 3) + (NW'(c_sum) << 1) + NW'(WINDOW_LEN / 2);

  always_ff @(posedge clk) begin
    if (rst) begin
      d_v <= 1'b0;
    end else if (d_ready) begin
      d_v <= c_v;
    end
  end

  always_ff @(posedge clk) begin
    if (d_ready) begin
      d_prod <= PRW'(c_num) * PRW'(RECIP);
      d_idx  <= c_idx;
    end
  end

  assign d_quot = QW'(d_prod >> K);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (o_ready) begin
      out_valid <= d_v;
    end
  end

  always_ff @(posedge clk) begin
    if (o_ready) begin
      average_tenths <= (d_quot > QW'(AVG_MAX)) ? AVG_MAX : d_quot[AVG_W-1:0];
      access_index   <= d_idx;
    end
  end

  // checks
  `HWMA_ASSERT_NOW(a_sum_bound, clk, rst, 1'b1, window_sum <= SW'(SUM_MAX))
  `HWMA_ASSERT_NOW(a_rmw_apart, clk, rst, b_v, ring_pos != b_pos)
  `HWMA_ASSERT_NOW(a_stall_cause, clk, rst, in_stall, b_v && c_v && d_v)
  `HWMA_ASSERT_NEXT(a_open_cleared, clk, rst, in_fire && last_chunk, partial_weight == '0)

endmodule

/* verif/tb.sv */
module tb;
  import hwma_pkg::*;

  localparam int WINDOW_LEN  = 10;
  localparam int MAX_WEIGHT  = 8 * 64;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 200;
  localparam int DRAIN_GAP   = 12;

  localparam logic [DATA_W-1:0] ALL1 = {DATA_W{1'b1}};
  localparam logic [DATA_W-1:0] ALT  = 64'hAAAA_AAAA_AAAA_AAAA;

  typedef struct packed {
    logic [AVG_W-1:0] avg;
    logic [IDX_W-1:0] idx;
  } avg_result_t;

  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic [BCNT_W-1:0] bcnt;
    logic              last;
    logic              pinned;   // avg column holds the known answer
    logic [AVG_W-1:0]  avg;
  } stim_row_t;

  // window 0..19: accesses 0..9 fill the ring, 10 and 11 report
  localparam stim_row_t DIRECTED_ROWS [22] = '{
    '{ALL1,  4'd8,  1'b1, 1'b0, 13'd0},    // access 0: full chunk, 64
    '{ALL1,  4'd15, 1'b1, 1'b0, 13'd0},    // access 1: count above eight, 64
    '{ALL1,  4'd0,  1'b1, 1'b0, 13'd0},    // access 2: empty chunk still closes
    '{ALL1,  4'd3,  1'b0, 1'b0, 13'd0},    // access 3: two chunks, 24
    '{64'd0, 4'd8,  1'b1, 1'b0, 13'd0},
    '{ALL1,  4'd8,  1'b0, 1'b0, 13'd0},    // access 4: ten full chunks, saturates
    '{ALL1,  4'd8,  1'b0, 1'b0, 13'd0},
    '{ALL1,  4'd8,  1'b0, 1'b0, 13'd0},
    '{ALL1,  4'd8,  1'b0, 1'b0, 13'd0},
    '{ALL1,  4'd8,  1'b0, 1'b0, 13'd0},
    '{ALL1,  4'd8,  1'b0, 1'b0, 13'd0},
    '{ALL1,  4'd8,  1'b0, 1'b0, 13'd0},
    '{ALL1,  4'd8,  1'b0, 1'b0, 13'd0},
    '{ALL1,  4'd8,  1'b0, 1'b0, 13'd0},
    '{ALL1,  4'd8,  1'b1, 1'b0, 13'd0},
    '{64'd0, 4'd8,  1'b1, 1'b0, 13'd0},    // accesses 5..9: zero weight
    '{64'd0, 4'd8,  1'b1, 1'b0, 13'd0},
    '{64'd0, 4'd8,  1'b1, 1'b0, 13'd0},
    '{64'd0, 4'd8,  1'b1, 1'b0, 13'd0},
    '{64'd0, 4'd8,  1'b1, 1'b0, 13'd0},
    '{ALL1,  4'd8,  1'b1, 1'b1, 13'd664},  // access 10: 64+0+24+512+0*5+64
    '{ALT,   4'd5,  1'b1, 1'b0, 13'd0}     // access 11
  };

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [DATA_W-1:0]    data_chunk = '0;
  logic [BCNT_W-1:0]    byte_count = '0;
  logic                 last_chunk = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [AVG_W-1:0]     average_tenths;
  logic [IDX_W-1:0]     access_index;
  logic                 cfg_write = 1'b0;
  logic [REG_IDX_W-1:0] cfg_index = '0;
  logic [IDX_W-1:0]     cfg_data = '0;

  hamming_weight_moving_average uut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .data_chunk     (data_chunk),
    .byte_count     (byte_count),
    .last_chunk     (last_chunk),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .average_tenths (average_tenths),
    .access_index   (access_index),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // predictor state
  int unsigned      ring_w [WINDOW_LEN];
  int unsigned      ring_pos;
  int unsigned      win_sum;
  int unsigned      part_w;
  logic [IDX_W-1:0] acc_count;
  logic [IDX_W-1:0] win_lo;
  logic [IDX_W-1:0] win_hi;

  avg_result_t pending_avgs [$];
  avg_result_t got;
  avg_result_t want;
  int          errors = 0;
  int          sent_chunks = 0;
  int          cycle_count = 0;
  bit          calm = 1'b0;
  bit          hold_req = 1'b0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic int unsigned set_bits_in_chunk(input logic [DATA_W-1:0] d,
                                                    input logic [BCNT_W-1:0] n);
    int unsigned lanes;
    int unsigned total;
    lanes = (n > 4'd8) ? 8 : n;
    total = 0;
    for (int k = 0; k < DATA_W; k++) begin
      if (k < lanes * 8) total += d[k];
    end
    return total;
  endfunction

  function automatic bit predict_moving_average(input logic [DATA_W-1:0] d,
                                                input logic [BCNT_W-1:0] n,
                                                input logic last,
                                                output avg_result_t r);
    int unsigned w;
    int unsigned p;
    int unsigned avg;
    bit          hit;
    hit = 1'b0;
    r   = '0;
    w   = part_w + set_bits_in_chunk(d, n);
    if (w > MAX_WEIGHT) w = MAX_WEIGHT;
    part_w = w;
    if (last) begin
      part_w = 0;
      if (acc_count >= win_lo && acc_count < win_hi) begin
        p = ring_pos;
        win_sum = win_sum - ring_w[p] + w;
        ring_w[p] = w;
        ring_pos = (p + 1) % WINDOW_LEN;
        if (32'(acc_count) - 32'(win_lo) >= WINDOW_LEN) begin
          avg = (win_sum * 10 + WINDOW_LEN / 2) / WINDOW_LEN;
          if (avg > AVG_MAX) avg = AVG_MAX;
          r.avg = AVG_W'(avg);
          r.idx = acc_count;
          hit = 1'b1;
        end
      end
      if (acc_count != IDX_MAX) acc_count++;
    end
    return hit;
  endfunction

  // entered and left at a falling edge; valid stays up for back-to-back chunks
  task automatic send_chunk(input logic [DATA_W-1:0] d, input logic [BCNT_W-1:0] n,
                            input logic last, input logic pinned,
                            input logic [AVG_W-1:0] pinned_avg);
    avg_result_t r;
    while (!calm && $urandom_range(0, 99) < 7) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    data_chunk <= d;
    byte_count <= n;
    last_chunk <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (predict_moving_average(d, n, last, r)) begin
      if (pinned) r.avg = pinned_avg;
      pending_avgs.push_back(r);
    end
    sent_chunks++;
    @(negedge clk);
  endtask

  task automatic random_access();
    int               n_chunks;
    int               kind;
    logic [DATA_W-1:0] d;
    logic [BCNT_W-1:0] n;
    n_chunks = ($urandom_range(0, 19) == 0) ? $urandom_range(8, 12) : $urandom_range(1, 4);
    for (int c = 0; c < n_chunks; c++) begin
      kind = $urandom_range(0, 9);
      d = {$urandom, $urandom};
      n = ($urandom_range(0, 3) == 0) ? BCNT_W'($urandom_range(0, 15)) : 4'd8;
      if (kind == 0) d = ALL1;
      else if (kind == 1) d = '0;
      // long accesses mostly run the weight into saturation
      if (n_chunks >= 8 && kind < 7) begin
        d = ALL1;
        n = 4'd8;
      end
      send_chunk(d, n, c == n_chunks - 1, 1'b0, '0);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_avgs.size() != 0) @(negedge clk);
    repeat (DRAIN_GAP) @(negedge clk);
  endtask

  task automatic set_window(input logic [IDX_W-1:0] lo, input logic [IDX_W-1:0] hi);
    cfg_write <= 1'b1;
    cfg_index <= REG_WINDOW_START;
    cfg_data  <= lo;
    @(negedge clk);
    cfg_index <= REG_WINDOW_END;
    cfg_data  <= hi;
    @(negedge clk);
    cfg_write <= 1'b0;
    win_lo = lo;
    win_hi = hi;
  endtask

  task automatic run_phase(input logic [IDX_W-1:0] lo, input logic [IDX_W-1:0] hi,
                           input int n, input bit quiet, input bit hold);
    int goal;
    drain();
    set_window(lo, hi);
    calm = quiet;
    goal = sent_chunks + n;
    while (sent_chunks < goal) begin
      if (hold && sent_chunks >= goal - n / 2) begin
        hold_req = 1'b1;
        hold = 1'b0;
      end
      random_access();
    end
  endtask

  // receiver: random stalls plus one long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= !calm && $urandom_range(0, 99) < 7;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      got = '{avg: average_tenths, idx: access_index};
      if (pending_avgs.size() == 0) begin
        $error("average %0d for access %0d with no transaction pending", got.avg, got.idx);
        errors++;
      end else begin
        want = pending_avgs.pop_front();
        if (got.avg !== want.avg) begin
          $error("average_tenths: expected %0d, got %0d", want.avg, got.avg);
          errors++;
        end
        if (got.idx !== want.idx) begin
          $error("access_index: expected %0d, got %0d", want.idx, got.idx);
          errors++;
        end
      end
    end
  end

  initial begin
    for (int k = 0; k < WINDOW_LEN; k++) ring_w[k] = 0;
    ring_pos  = 0;
    win_sum   = 0;
    part_w    = 0;
    acc_count = '0;
    win_lo    = '0;
    win_hi    = IDX_MAX;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    set_window('0, IDX_W'(20));
    foreach (DIRECTED_ROWS[r]) begin
      send_chunk(DIRECTED_ROWS[r].data, DIRECTED_ROWS[r].bcnt, DIRECTED_ROWS[r].last,
                 DIRECTED_ROWS[r].pinned, DIRECTED_ROWS[r].avg);
    end

    // start above end, then an empty window
    run_phase(IDX_MAX, '0, 40, 1'b0, 1'b0);
    run_phase(acc_count + IDX_W'(2), acc_count + IDX_W'(2), 30, 1'b0, 1'b0);
    // open-ended window with a long hold-off on the result side
    run_phase(acc_count + IDX_W'(3), IDX_MAX, 400, 1'b0, 1'b1);
    // window starts back in the past; ring keeps its old weights
    run_phase(acc_count - IDX_W'(4), acc_count + IDX_W'(40), 250, 1'b1, 1'b0);
    run_phase('0, IDX_MAX, 210, 1'b0, 1'b0);

    drain();
    if (pending_avgs.size() != 0) begin
      $error("%0d averages never arrived", pending_avgs.size());
      errors++;
    end
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
